[rtl/vtip_pkg.sv]
// ----------------------------------------------------------------------------
// vtip_pkg
// Shared codes, register map and result bundle for the timer/port block.
// ----------------------------------------------------------------------------
`default_nettype none

package vtip_pkg;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_TICK  = 2'd2
    } cmd_t;

    // register map
    localparam logic [3:0] ADDR_ORB   = 4'd0;
    localparam logic [3:0] ADDR_ORA   = 4'd1;
    localparam logic [3:0] ADDR_DDRB  = 4'd2;
    localparam logic [3:0] ADDR_DDRA  = 4'd3;
    localparam logic [3:0] ADDR_T1CL  = 4'd4;
    localparam logic [3:0] ADDR_T1CH  = 4'd5;
    localparam logic [3:0] ADDR_T1LL  = 4'd6;
    localparam logic [3:0] ADDR_T1LH  = 4'd7;
    localparam logic [3:0] ADDR_T2CL  = 4'd8;
    localparam logic [3:0] ADDR_T2CH  = 4'd9;
    localparam logic [3:0] ADDR_SR    = 4'd10;
    localparam logic [3:0] ADDR_ACR   = 4'd11;
    localparam logic [3:0] ADDR_PCR   = 4'd12;
    localparam logic [3:0] ADDR_IFR   = 4'd13;
    localparam logic [3:0] ADDR_IER   = 4'd14;
    localparam logic [3:0] ADDR_ORA_NH = 4'd15;

    // DAC mux select on port B bits 2..1
    localparam logic [1:0] DAC_SEL_Y         = 2'd0;
    localparam logic [1:0] DAC_SEL_OFFSET    = 2'd1;
    localparam logic [1:0] DAC_SEL_INTENSITY = 2'd2;

    localparam logic [7:0] FLAG_T1       = 8'h40;
    localparam logic [7:0] FLAG_T2       = 8'h20;
    localparam logic [7:0] FLAG_SRC_MASK = 8'h7F;
    localparam logic [7:0] IER_READ_SET  = 8'h80;
    localparam logic [2:0] PCR_ZERO_CODE = 3'd6;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq;
        logic [7:0] port_b;
        logic [7:0] port_a;
        logic [7:0] y_drive;
        logic [7:0] offset_drive;
        logic [7:0] intensity;
        logic       zero_beam;
    } result_t;

endpackage

`default_nettype wire

[rtl/vtip_core.sv]
// ----------------------------------------------------------------------------
// vtip_core
// Register file, timers, flags and DAC latches; one request per step.
// ----------------------------------------------------------------------------
`default_nettype none

module vtip_core
    import vtip_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [1:0] command,
    input  wire logic [3:0] reg_addr,
    input  wire logic [7:0] write_data,
    output result_t         result
);

    logic [7:0]  out_b_reg,  out_b_next;
    logic [7:0]  out_a_reg,  out_a_next;
    logic [7:0]  dir_b_reg,  dir_b_next;
    logic [7:0]  dir_a_reg,  dir_a_next;
    logic [15:0] t1_count_reg, t1_count_next;
    logic [7:0]  t1_latch_lo_reg, t1_latch_lo_next;
    logic [7:0]  t1_latch_hi_reg, t1_latch_hi_next;
    logic [15:0] t2_count_reg, t2_count_next;
    logic [7:0]  t2_latch_lo_reg, t2_latch_lo_next;
    logic [7:0]  t2_latch_hi_reg, t2_latch_hi_next;
    logic [7:0]  shift_reg, shift_next;
    logic [7:0]  aux_ctrl_reg, aux_ctrl_next;
    logic [7:0]  periph_ctrl_reg, periph_ctrl_next;
    logic [7:0]  flag_reg, flag_next;
    logic [7:0]  enable_reg, enable_next;
    logic        pb7_level_reg, pb7_level_next;
    logic        tick_phase_reg, tick_phase_next;
    logic [7:0]  y_latch_reg, y_latch_next;
    logic [7:0]  offset_latch_reg, offset_latch_next;
    logic [7:0]  intensity_latch_reg, intensity_latch_next;
    logic [7:0]  rd;
    logic        irq_now;
    logic        dac_load;

    always_comb
    begin
        out_b_next           = out_b_reg;
        out_a_next           = out_a_reg;
        dir_b_next           = dir_b_reg;
        dir_a_next           = dir_a_reg;
        t1_count_next        = t1_count_reg;
        t1_latch_lo_next     = t1_latch_lo_reg;
        t1_latch_hi_next     = t1_latch_hi_reg;
        t2_count_next        = t2_count_reg;
        t2_latch_lo_next     = t2_latch_lo_reg;
        t2_latch_hi_next     = t2_latch_hi_reg;
        shift_next           = shift_reg;
        aux_ctrl_next        = aux_ctrl_reg;
        periph_ctrl_next     = periph_ctrl_reg;
        flag_next            = flag_reg;
        enable_next          = enable_reg;
        pb7_level_next       = pb7_level_reg;
        tick_phase_next      = tick_phase_reg;
        y_latch_next         = y_latch_reg;
        offset_latch_next    = offset_latch_reg;
        intensity_latch_next = intensity_latch_reg;
        rd                   = '0;
        dac_load             = 1'b0;

        unique case (command)
            CMD_READ:
            begin
                unique case (reg_addr)
                    ADDR_DDRB: rd = dir_b_reg;
                    ADDR_DDRA: rd = dir_a_reg;
                    ADDR_T1CL:
                    begin
                        rd        = t1_count_reg[7:0];
                        flag_next = flag_next & ~FLAG_T1;
                    end
                    ADDR_T1CH: rd = t1_count_reg[15:8];
                    ADDR_T1LL: rd = t1_latch_lo_reg;
                    ADDR_T1LH: rd = t1_latch_hi_reg;
                    ADDR_T2CL:
                    begin
                        rd        = t2_count_reg[7:0];
                        flag_next = flag_next & ~FLAG_T2;
                    end
                    ADDR_T2CH: rd = t2_count_reg[15:8];
                    ADDR_SR:   rd = shift_reg;
                    ADDR_ACR:  rd = aux_ctrl_reg;
                    ADDR_PCR:  rd = periph_ctrl_reg;
                    ADDR_IFR:  rd = flag_reg;
                    ADDR_IER:  rd = enable_reg | IER_READ_SET;
                    default:   rd = '0;  // no input pins on the ports
                endcase
            end
            CMD_WRITE:
            begin
                unique case (reg_addr)
                    ADDR_ORB:
                    begin
                        out_b_next = write_data;
                        dac_load   = 1'b1;
                    end
                    ADDR_ORA, ADDR_ORA_NH:
                    begin
                        out_a_next = write_data;
                        dac_load   = 1'b1;
                    end
                    ADDR_DDRB: dir_b_next = write_data;
                    ADDR_DDRA: dir_a_next = write_data;
                    ADDR_T1CL, ADDR_T1LL: t1_latch_lo_next = write_data;
                    ADDR_T1LH: t1_latch_hi_next = write_data;
                    ADDR_T1CH:
                    begin
                        t1_latch_hi_next = write_data;
                        t1_count_next    = {write_data, t1_latch_lo_reg};
                        flag_next        = flag_next & ~FLAG_T1;
                        if (aux_ctrl_reg[7])
                        begin
                            pb7_level_next = 1'b0;
                        end
                    end
                    ADDR_T2CL: t2_latch_lo_next = write_data;
                    ADDR_T2CH:
                    begin
                        t2_latch_hi_next = write_data;
                        t2_count_next    = {write_data, t2_latch_lo_reg};
                        flag_next        = flag_next & ~FLAG_T2;
                    end
                    ADDR_SR:  shift_next = write_data;
                    ADDR_ACR: aux_ctrl_next = write_data;
                    ADDR_PCR: periph_ctrl_next = write_data;
                    ADDR_IFR: flag_next = flag_next & ~(write_data & FLAG_SRC_MASK);
                    ADDR_IER:
                    begin
                        if (write_data[7])
                        begin
                            enable_next = enable_reg | (write_data & FLAG_SRC_MASK);
                        end
                        else
                        begin
                            enable_next = enable_reg & ~(write_data & FLAG_SRC_MASK);
                        end
                    end
                    default: ;
                endcase

                // route port A through the DAC while port B bit 0 is low
                if (dac_load && !out_b_next[0])
                begin
                    unique case (out_b_next[2:1])
                        DAC_SEL_Y:         y_latch_next = out_a_next;
                        DAC_SEL_OFFSET:    offset_latch_next = out_a_next;
                        DAC_SEL_INTENSITY: intensity_latch_next = out_a_next;
                        default: ;
                    endcase
                end
            end
            CMD_TICK:
            begin
                tick_phase_next = ~tick_phase_reg;
                // timers advance on every other tick; T2 only while ACR bit 5 is clear
                if (tick_phase_next)
                begin
                    t1_count_next = t1_count_reg - 16'd1;
                    if (t1_count_next == 16'd0)
                    begin
                        if (aux_ctrl_reg[7])
                        begin
                            pb7_level_next = ~pb7_level_reg;
                        end
                        if (aux_ctrl_reg[6])
                        begin
                            t1_count_next = {t1_latch_hi_reg, t1_latch_lo_reg};
                        end
                        flag_next = flag_next | FLAG_T1;
                    end
                    if (aux_ctrl_reg[7])
                    begin
                        out_b_next[7] = pb7_level_next;
                    end
                    if (!aux_ctrl_reg[5])
                    begin
                        t2_count_next = t2_count_reg - 16'd1;
                        if (t2_count_next == 16'd0)
                        begin
                            flag_next = flag_next | FLAG_T2;
                        end
                    end
                end
            end
            default: ;
        endcase

        irq_now      = |(enable_next & flag_next & FLAG_SRC_MASK);
        flag_next[7] = irq_now;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_b_reg           <= '0;
            out_a_reg           <= '0;
            dir_b_reg           <= '0;
            dir_a_reg           <= '0;
            t1_count_reg        <= '0;
            t1_latch_lo_reg     <= '0;
            t1_latch_hi_reg     <= '0;
            t2_count_reg        <= '0;
            t2_latch_lo_reg     <= '0;
            t2_latch_hi_reg     <= '0;
            shift_reg           <= '0;
            aux_ctrl_reg        <= '0;
            periph_ctrl_reg     <= '0;
            flag_reg            <= '0;
            enable_reg          <= '0;
            pb7_level_reg       <= 1'b0;
            tick_phase_reg      <= 1'b0;
            y_latch_reg         <= '0;
            offset_latch_reg    <= '0;
            intensity_latch_reg <= '0;
        end
        else if (step)
        begin
            out_b_reg           <= out_b_next;
            out_a_reg           <= out_a_next;
            dir_b_reg           <= dir_b_next;
            dir_a_reg           <= dir_a_next;
            t1_count_reg        <= t1_count_next;
            t1_latch_lo_reg     <= t1_latch_lo_next;
            t1_latch_hi_reg     <= t1_latch_hi_next;
            t2_count_reg        <= t2_count_next;
            t2_latch_lo_reg     <= t2_latch_lo_next;
            t2_latch_hi_reg     <= t2_latch_hi_next;
            shift_reg           <= shift_next;
            aux_ctrl_reg        <= aux_ctrl_next;
            periph_ctrl_reg     <= periph_ctrl_next;
            flag_reg            <= flag_next;
            enable_reg          <= enable_next;
            pb7_level_reg       <= pb7_level_next;
            tick_phase_reg      <= tick_phase_next;
            y_latch_reg         <= y_latch_next;
            offset_latch_reg    <= offset_latch_next;
            intensity_latch_reg <= intensity_latch_next;
        end
    end

    always_comb
    begin
        result.read_data    = rd;
        result.irq          = irq_now;
        result.port_b       = out_b_next;
        result.port_a       = out_a_next;
        result.y_drive      = y_latch_next;
        result.offset_drive = offset_latch_next;
        result.intensity    = intensity_latch_next;
        result.zero_beam    = (periph_ctrl_next[3:1] == PCR_ZERO_CODE);
    end

endmodule

`default_nettype wire

[rtl/via_timer_interrupt_port_block.sv]
// ----------------------------------------------------------------------------
// via_timer_interrupt_port_block
// 6522-style port/timer/interrupt adapter with a multiplexed DAC latch set.
// ----------------------------------------------------------------------------
// Request channel (req_valid / req_stall): command, reg_addr, write_data.
// Each request is a bus read, a bus write or a clock tick. Every request
// gives exactly one response on the response channel (rsp_valid / rsp_stall)
// carrying the read byte, the interrupt line, both port outputs, the three
// DAC latches and the zero-beam control.
// A request is first held in the request register; when it advances, the
// core state and the response register are updated together from it.
// Throughput: one request per cycle while the response is not stalled. The
// whole update is one pass of logic from the request register to the
// response register and the state. A stalled response holds; the request
// register keeps one request behind it, and req_stall rises only while
// both are full and rsp_stall is high. Reset clears every core register,
// both counters, the flags and the latches, and empties both stages; the
// request and response payload registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module via_timer_interrupt_port_block
    import vtip_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_stall,
    input  wire logic [1:0] command,
    input  wire logic [3:0] reg_addr,
    input  wire logic [7:0] write_data,
    output logic            rsp_valid,
    input  wire logic       rsp_stall,
    output logic [7:0]      read_data,
    output logic            irq,
    output logic [7:0]      port_b,
    output logic [7:0]      port_a,
    output logic [7:0]      y_drive,
    output logic [7:0]      offset_drive,
    output logic [7:0]      intensity,
    output logic            zero_beam
);

    logic       req_valid_reg, req_valid_next;
    logic [1:0] command_reg;
    logic [3:0] reg_addr_reg;
    logic [7:0] write_data_reg;
    logic       rsp_valid_reg, rsp_valid_next;
    result_t    rsp_reg;
    result_t    result;
    logic       accept;
    logic       advance;

    assign advance   = req_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = req_valid_reg && !advance;
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (accept)
        begin
            req_valid_next = 1'b1;
        end
        else if (advance)
        begin
            req_valid_next = 1'b0;
        end

        rsp_valid_next = rsp_valid_reg;
        if (advance)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            command_reg    <= command;
            reg_addr_reg   <= reg_addr;
            write_data_reg <= write_data;
        end
        if (advance)
        begin
            rsp_reg <= result;
        end
    end

    vtip_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .command    (command_reg),
        .reg_addr   (reg_addr_reg),
        .write_data (write_data_reg),
        .result     (result)
    );

    assign rsp_valid    = rsp_valid_reg;
    assign read_data    = rsp_reg.read_data;
    assign irq          = rsp_reg.irq;
    assign port_b       = rsp_reg.port_b;
    assign port_a       = rsp_reg.port_a;
    assign y_drive      = rsp_reg.y_drive;
    assign offset_drive = rsp_reg.offset_drive;
    assign intensity    = rsp_reg.intensity;
    assign zero_beam    = rsp_reg.zero_beam;

endmodule

`default_nettype wire

[rtl/vtip_checker.sv]
// ----------------------------------------------------------------------------
// vtip_checker
// Port-level checks on the request and response channels.
// ----------------------------------------------------------------------------
`default_nettype none

module vtip_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       req_valid,
    input wire logic       req_stall,
    input wire logic       rsp_valid,
    input wire logic       rsp_stall,
    input wire logic [7:0] read_data,
    input wire logic [7:0] port_b
);

    // a stalled response holds its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(read_data) && $stable(port_b))
        else $error("response changed while stalled");

    // back-pressure on requests only comes from a blocked response
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> rsp_valid && rsp_stall)
        else $error("request stalled without a blocked response");

    // an accepted request reaches the response register when it is free
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) ##1 !rsp_stall |=> rsp_valid)
        else $error("accepted request did not produce a response");

endmodule

bind via_timer_interrupt_port_block vtip_checker u_vtip_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .read_data (read_data),
    .port_b    (port_b)
);

`default_nettype wire
